@@ hw/rtl/idiv_pkg.sv @@
// ----------------------------------------------------------------------------
// idiv_pkg
// Shared widths, codes and types of the 32-bit integer divider.
// ----------------------------------------------------------------------------
`default_nettype none

package idiv_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned CNT_WIDTH  = $clog2(DATA_WIDTH);
   localparam int unsigned ACT_WIDTH  = 2;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [CNT_WIDTH-1:0]  count_type;

   typedef enum logic [ACT_WIDTH-1:0] {
      ACT_UQUO = 2'd0,
      ACT_UREM = 2'd1,
      ACT_SQUO = 2'd2,
      ACT_SREM = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIX
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } core_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/idiv_if.sv @@
// ----------------------------------------------------------------------------
// idiv_req_if / idiv_rsp_if
// Valid/ready channels for divide requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface idiv_req_if;
   logic                                valid;
   logic                                ready;
   logic [idiv_pkg::ACT_WIDTH-1:0]      action;
   logic [idiv_pkg::DATA_WIDTH-1:0]     dividend;
   logic [idiv_pkg::DATA_WIDTH-1:0]     divisor;

   modport source (output valid, output action, output dividend, output divisor,
                   input ready);
   modport sink   (input valid, input action, input dividend, input divisor,
                   output ready);
endinterface

interface idiv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [idiv_pkg::DATA_WIDTH-1:0]     result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/int_divider_32.sv @@
// ----------------------------------------------------------------------------
// int_divider_32
// 32-bit signed/unsigned integer divider, quotient or remainder per request.
//
// A request on req_if carries action, dividend and divisor; req_if.ready is
// high only while the sequencer is idle. The request's operands are reduced
// to magnitudes on acceptance, then the shift-subtract core runs 32 steps,
// one quotient bit each, and a last cycle applies the signs and loads the
// result register. A new request is accepted only once that result has been
// loaded, and the result shows on rsp_if in the cycle that follows the sign
// fix-up cycle.
// Signed quotients truncate toward zero, signed remainders follow the
// dividend's sign, a zero divisor yields zero, and the most negative value
// divided by minus one yields 0x80000000.
// The result register lets a new request start while a result waits; if
// rsp_if stalls, the next result is held in the sign fix-up cycle until the
// register frees. Reset empties the result register and returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module int_divider_32 (
   input  wire logic    clock,
   input  wire logic    reset,
   idiv_req_if.sink     req_if,
   idiv_rsp_if.source   rsp_if
);

   idiv_pkg::state_type       state_ff, state_in;
   idiv_pkg::count_type       count_ff, count_in;
   logic                      zero_ff, zero_in;
   logic                      neg_ff, neg_in;
   logic                      sel_rem_ff, sel_rem_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   idiv_pkg::word_type        result_ff, result_in;

   idiv_pkg::core_ctrl_type   ctrl;
   idiv_pkg::action_type      act;
   idiv_pkg::word_type        abs_n, abs_d, quotient, remainder, picked;
   logic                      req_ready, accept, out_load, is_signed, is_rem, sn, sd;

   assign act       = idiv_pkg::action_type'(req_if.action);
   assign is_signed = (act == idiv_pkg::ACT_SQUO) || (act == idiv_pkg::ACT_SREM);
   assign is_rem    = (act == idiv_pkg::ACT_UREM) || (act == idiv_pkg::ACT_SREM);
   assign sn        = is_signed && req_if.dividend[idiv_pkg::DATA_WIDTH-1];
   assign sd        = is_signed && req_if.divisor[idiv_pkg::DATA_WIDTH-1];
   assign abs_n     = sn ? idiv_pkg::word_type'('0) - req_if.dividend : req_if.dividend;
   assign abs_d     = sd ? idiv_pkg::word_type'('0) - req_if.divisor : req_if.divisor;
   assign accept    = req_if.valid && req_ready;

   idiv_core u_core (
      .clock     (clock),
      .ctrl      (ctrl),
      .dividend  (abs_n),
      .divisor   (abs_d),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         idiv_pkg::ST_IDLE: begin
            if (accept) state_in = idiv_pkg::ST_DIV;
         end
         idiv_pkg::ST_DIV: begin
            if (count_ff == '0) state_in = idiv_pkg::ST_FIX;
         end
         idiv_pkg::ST_FIX: begin
            if (out_load) state_in = idiv_pkg::ST_IDLE;
         end
         default: state_in = idiv_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      ctrl      = '0;
      out_load  = 1'b0;
      case (state_ff)
         idiv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_if.valid;
         end
         idiv_pkg::ST_DIV: begin
            ctrl.step = 1'b1;
         end
         idiv_pkg::ST_FIX: begin
            out_load = !rsp_valid_ff || rsp_if.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign picked = sel_rem_ff ? remainder : quotient;

   always_comb begin
      count_in     = count_ff;
      zero_in      = zero_ff;
      neg_in       = neg_ff;
      sel_rem_in   = sel_rem_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         count_in   = idiv_pkg::count_type'(idiv_pkg::DATA_WIDTH - 1);
         zero_in    = req_if.divisor == '0;
         sel_rem_in = is_rem;
         neg_in     = is_rem ? sn : (sn ^ sd);
      end else if (ctrl.step) begin
         count_in = count_ff - 1'b1;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (zero_ff) result_in = '0;
         else if (neg_ff) result_in = idiv_pkg::word_type'('0) - picked;
         else result_in = picked;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idiv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      zero_ff    <= zero_in;
      neg_ff     <= neg_in;
      sel_rem_ff <= sel_rem_in;
      result_ff  <= result_in;
   end

   assign req_if.ready  = req_ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.result = result_ff;

endmodule

`default_nettype wire

@@ hw/rtl/idiv_core.sv @@
// ----------------------------------------------------------------------------
// idiv_core
// Restoring shift-subtract unit: one quotient bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_core (
   input  wire logic                      clock,
   input  wire idiv_pkg::core_ctrl_type   ctrl,
   input  wire idiv_pkg::word_type        dividend,
   input  wire idiv_pkg::word_type        divisor,
   output idiv_pkg::word_type             quotient,
   output idiv_pkg::word_type             remainder
);

   idiv_pkg::word_type                    quo_ff, quo_in;
   idiv_pkg::word_type                    rem_ff, rem_in;
   idiv_pkg::word_type                    div_ff, div_in;
   logic [idiv_pkg::DATA_WIDTH:0]         trial;
   idiv_pkg::word_type                    diff;
   logic                                  fits;

   assign trial = {rem_ff, quo_ff[idiv_pkg::DATA_WIDTH-1]};
   assign diff  = trial[idiv_pkg::DATA_WIDTH-1:0] - div_ff;
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (ctrl.load) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (ctrl.step) begin
         quo_in = {quo_ff[idiv_pkg::DATA_WIDTH-2:0], fits};
         rem_in = fits ? diff : trial[idiv_pkg::DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/idiv_checker.sv @@
// ----------------------------------------------------------------------------
// idiv_checker
// Port-level checks on the divider's request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module idiv_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire idiv_pkg::word_type       rsp_result
);

   // drop ready after an accepted request
   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("idiv: ready after accepted request");

   // results appear only out of a busy interval
   a_rsp_after_work : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("idiv: result without a divide in progress");

   // reset empties the output and returns to idle
   a_reset_state : assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("idiv: bad state after reset");

   // hold a stalled result
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("idiv: stalled result changed");

endmodule

bind int_divider_32 idiv_checker u_idiv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_result (rsp_if.result)
);

`default_nettype wire
